[hw/rtl/ucv_pkg.sv]
package ucv_pkg;

   localparam int MAX_RINGS_DEF   = 256;
   localparam int MAX_SECTORS_DEF = 256;
   localparam int ANGLE_BITS_DEF  = 16;

   localparam int MIN_RINGS   = 2;
   localparam int MIN_SECTORS = 3;

   localparam int SINE_LAT = 8;

   localparam logic [31:0] K1 = 32'd1686629713;
   localparam logic [31:0] K3 = 32'd693598668;
   localparam logic [31:0] K5 = 32'd85569306;
   localparam logic [31:0] K7 = 32'd5026993;
   localparam logic [31:0] K9 = 32'd172272;

   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_RADIUS  = 2'd0;
   localparam logic [1:0] REG_RINGS   = 2'd1;
   localparam logic [1:0] REG_SECTORS = 2'd2;

   localparam logic [2:0] SLOT_FIRST = 3'd0;
   localparam logic [2:0] SLOT_LAST  = 3'd5;

   typedef struct packed {
      logic [7:0] ring;
      logic [7:0] sector;
      logic       bad;
   } ucv_cell_type;

   typedef struct packed {
      logic       vld;
      logic [2:0] slot;
      logic       bad;
      logic       last;
   } ucv_tag_type;

   function automatic logic [8:0] clamp_count(logic [8:0] cnt, int lo, int hi);
      logic [8:0] res;
      if (int'(cnt) < lo) begin
         res = 9'(lo);
      end else if (int'(cnt) > hi) begin
         res = 9'(hi);
      end else begin
         res = cnt;
      end
      return res;
   endfunction

endpackage

[hw/rtl/ucv_front.sv]
module ucv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_ring_index,
   input  logic [7:0]           req_sector_index,
   input  logic [8:0]           rings_eff,
   input  logic [8:0]           sectors_eff,
   output logic                 q_valid,
   input  logic                 q_pop,
   output ucv_pkg::ucv_cell_type q_cell
);
   import ucv_pkg::*;

   ucv_cell_type ent_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;
   ucv_cell_type ent_in;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cell    = ent_ff[rd_ptr_ff];

   always_comb begin
      ent_in.ring   = req_ring_index;
      ent_in.sector = req_sector_index;
      ent_in.bad    = ({1'b0, req_ring_index} >= rings_eff) ||
                      ({1'b0, req_sector_index} >= sectors_eff);
      wr_ptr_in     = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in        = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= ent_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_pop |-> cnt_ff != 2'd0)
      else $error("Cell queue popped while empty.");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("Cell queue holds more words than it has entries.");

endmodule

[hw/rtl/ucv_div.sv]
module ucv_div #(
   parameter int NW = 26,
   parameter int DW = 10,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);
   localparam int CW = NW + DW;

   logic [NW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [NW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] quo_prev;
      logic [CW-1:0] dsh;
      logic          ge;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      always_comb begin
         dsh    = CW'(den_prev) << (QW - 1 - k);
         ge     = CW'(rem_prev) >= dsh;
         rem_in = ge ? NW'(CW'(rem_prev) - dsh) : rem_prev;
         quo_in = quo_prev;
         quo_in[QW-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

[hw/rtl/ucv_sine.sv]
module ucv_sine #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic [16:0]           mag,
   output logic                  neg
);
   import ucv_pkg::*;

   localparam logic [30:0] ONE_Q30 = 31'(1) << 30;

   function automatic logic [31:0] q30_mul(logic [30:0] a, logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b);
      return p[61:30];
   endfunction

   logic [29:0] x30;
   logic [30:0] xa_in;
   logic [31:0] v_raw;

   logic [30:0] xa_ff, xb_ff, xc_ff, xd_ff, xe_ff, xf_ff;
   logic        qa_ff, qb_ff, qc_ff, qd_ff, qe_ff, qf_ff, qg_ff;
   logic [30:0] x2b_ff, x2c_ff, x2d_ff, x2e_ff;
   logic [30:0] sc_ff, sd_ff, se_ff, sf_ff;
   logic [30:0] vg_ff;
   logic [16:0] mag_ff;
   logic        neg_ff;

   always_comb begin
      x30   = {angle[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};
      xa_in = angle[ANGLE_BITS-2] ? (ONE_Q30 - {1'b0, x30}) : {1'b0, x30};
      v_raw = q30_mul(sf_ff, xf_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xa_ff  <= xa_in;
         qa_ff  <= angle[ANGLE_BITS-1];

         xb_ff  <= xa_ff;
         qb_ff  <= qa_ff;
         x2b_ff <= 31'(q30_mul(xa_ff, xa_ff));

         xc_ff  <= xb_ff;
         qc_ff  <= qb_ff;
         x2c_ff <= x2b_ff;
         sc_ff  <= 31'(K7 - q30_mul(31'(K9), x2b_ff));

         xd_ff  <= xc_ff;
         qd_ff  <= qc_ff;
         x2d_ff <= x2c_ff;
         sd_ff  <= 31'(K5 - q30_mul(sc_ff, x2c_ff));

         xe_ff  <= xd_ff;
         qe_ff  <= qd_ff;
         x2e_ff <= x2d_ff;
         se_ff  <= 31'(K3 - q30_mul(sd_ff, x2d_ff));

         xf_ff  <= xe_ff;
         qf_ff  <= qe_ff;
         sf_ff  <= 31'(K1 - q30_mul(se_ff, x2e_ff));

         qg_ff  <= qf_ff;
         vg_ff  <= (v_raw > 32'(ONE_Q30)) ? ONE_Q30 : v_raw[30:0];

         mag_ff <= 17'((32'(vg_ff) + 32'd8192) >> 14);
         neg_ff <= qg_ff && (vg_ff != 31'd0);
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

[hw/rtl/ucv_back.sv]
module ucv_back #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  ucv_pkg::ucv_cell_type q_cell,
   input  logic [15:0]           radius,
   input  logic [8:0]            rings_eff,
   input  logic [8:0]            sectors_eff,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [16:0]    rsp_pos_x,
   output logic signed [16:0]    rsp_pos_y,
   output logic signed [16:0]    rsp_pos_z,
   output logic [2:0]            rsp_corner_slot,
   output logic                  rsp_bad_index,
   output logic                  rsp_last_vertex
);
   import ucv_pkg::*;

   localparam int A    = ANGLE_BITS;
   localparam int QW   = A + 1;
   localparam int NW   = A + 10;
   localparam int DW   = 10;
   localparam int TAGD = QW + SINE_LAT + 2;
   localparam logic [A-1:0] QUARTER = {2'b01, {(A - 2){1'b0}}};

   logic         adv, done, take;
   logic         cur_vld_ff, cur_vld_in;
   ucv_cell_type cur_ff, cur_in;
   logic [2:0]   slot_ff, slot_in;
   logic         dr, ds;
   logic [8:0]   ii, jj;
   logic [NW-1:0] phi_num, th_num;
   logic [DW-1:0] phi_den, th_den;
   logic [QW-1:0] phi_q, th_q;
   logic [A-1:0]  phi_a, th_a;
   ucv_tag_type   issue;
   ucv_tag_type   tag_ff [TAGD];

   logic [16:0] sp, cp, st, ct;
   logic        nsp, ncp, nst, nct;

   logic [32:0] rsp1_ff, myr1_ff;
   logic [16:0] st1_ff, ct1_ff;
   logic        nsp1_ff, ncp1_ff, nst1_ff, nct1_ff;
   logic [49:0] mxr2_ff, mzr2_ff;
   logic [16:0] my2_ff;
   logic        negx2_ff, negz2_ff, ncp2_ff;
   logic [49:0] mx_sum, mz_sum;
   logic [16:0] mx, mz;
   logic [33:0] my_sum;

   logic        rsp_valid_ff;
   logic [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [2:0]  slot_out_ff;
   logic        bad_out_ff, last_out_ff;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign done  = cur_ff.bad || (slot_ff == SLOT_LAST);
   assign take  = adv && (!cur_vld_ff || done);
   assign q_pop = take && q_valid;

   always_comb begin
      unique case (slot_ff)
         3'd0:    begin dr = 1'b0; ds = 1'b0; end
         3'd1:    begin dr = 1'b1; ds = 1'b0; end
         3'd2:    begin dr = 1'b1; ds = 1'b1; end
         3'd3:    begin dr = 1'b0; ds = 1'b0; end
         3'd4:    begin dr = 1'b1; ds = 1'b1; end
         3'd5:    begin dr = 1'b0; ds = 1'b1; end
         default: begin dr = 1'b0; ds = 1'b0; end
      endcase
      ii       = {1'b0, cur_ff.ring} + 9'(dr);
      jj       = {1'b0, cur_ff.sector} + 9'(ds);
      phi_num  = NW'({ii, {A{1'b0}}}) + NW'(rings_eff);
      th_num   = NW'({jj, {A{1'b0}}}) + NW'(sectors_eff[8:1]);
      phi_den  = {rings_eff, 1'b0};
      th_den   = {1'b0, sectors_eff};
      issue.vld  = cur_vld_ff;
      issue.slot = slot_ff;
      issue.bad  = cur_ff.bad;
      issue.last = done;
      if (take) begin
         cur_vld_in = q_valid;
         cur_in     = q_cell;
         slot_in    = SLOT_FIRST;
      end else begin
         cur_vld_in = cur_vld_ff;
         cur_in     = cur_ff;
         slot_in    = slot_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
      end else if (adv) begin
         cur_vld_ff <= cur_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cur_ff  <= cur_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < TAGD; n++) begin
            tag_ff[n].vld <= 1'b0;
         end
      end else if (adv) begin
         tag_ff[0] <= issue;
         for (int n = 1; n < TAGD; n++) begin
            tag_ff[n] <= tag_ff[n-1];
         end
      end
   end

   ucv_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_phi (
      .clock (clock), .en (adv), .num (phi_num), .den (phi_den), .quo (phi_q)
   );

   ucv_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_theta (
      .clock (clock), .en (adv), .num (th_num), .den (th_den), .quo (th_q)
   );

   assign phi_a = phi_q[A-1:0];
   assign th_a  = th_q[A-1:0];

   ucv_sine #(.ANGLE_BITS(A)) u_sin_phi (
      .clock (clock), .en (adv), .angle (phi_a), .mag (sp), .neg (nsp)
   );
   ucv_sine #(.ANGLE_BITS(A)) u_cos_phi (
      .clock (clock), .en (adv), .angle (phi_a + QUARTER), .mag (cp), .neg (ncp)
   );
   ucv_sine #(.ANGLE_BITS(A)) u_sin_theta (
      .clock (clock), .en (adv), .angle (th_a), .mag (st), .neg (nst)
   );
   ucv_sine #(.ANGLE_BITS(A)) u_cos_theta (
      .clock (clock), .en (adv), .angle (th_a + QUARTER), .mag (ct), .neg (nct)
   );

   always_comb begin
      my_sum = 34'(myr1_ff) + 34'd32768;
      mx_sum = mxr2_ff + (50'(1) << 31);
      mz_sum = mzr2_ff + (50'(1) << 31);
      mx     = mx_sum[48:32];
      mz     = mz_sum[48:32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp1_ff  <= 33'(radius) * 33'(sp);
         myr1_ff  <= 33'(radius) * 33'(cp);
         st1_ff   <= st;
         ct1_ff   <= ct;
         nsp1_ff  <= nsp;
         ncp1_ff  <= ncp;
         nst1_ff  <= nst;
         nct1_ff  <= nct;

         mxr2_ff  <= 50'(rsp1_ff) * 50'(ct1_ff);
         mzr2_ff  <= 50'(rsp1_ff) * 50'(st1_ff);
         my2_ff   <= my_sum[32:16];
         negx2_ff <= nsp1_ff != nct1_ff;
         negz2_ff <= nsp1_ff != nst1_ff;
         ncp2_ff  <= ncp1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tag_ff[TAGD-1].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         slot_out_ff <= tag_ff[TAGD-1].bad ? SLOT_FIRST : tag_ff[TAGD-1].slot;
         bad_out_ff  <= tag_ff[TAGD-1].bad;
         last_out_ff <= tag_ff[TAGD-1].last;
         if (tag_ff[TAGD-1].bad) begin
            pos_x_ff <= '0;
            pos_y_ff <= '0;
            pos_z_ff <= '0;
         end else begin
            pos_x_ff <= (negx2_ff && mx != 17'd0) ? 17'(17'd0 - mx) : mx;
            pos_y_ff <= (ncp2_ff && my2_ff != 17'd0) ? 17'(17'd0 - my2_ff) : my2_ff;
            pos_z_ff <= (negz2_ff && mz != 17'd0) ? 17'(17'd0 - mz) : mz;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = signed'(pos_x_ff);
   assign rsp_pos_y       = signed'(pos_y_ff);
   assign rsp_pos_z       = signed'(pos_z_ff);
   assign rsp_corner_slot = slot_out_ff;
   assign rsp_bad_index   = bad_out_ff;
   assign rsp_last_vertex = last_out_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && bad_out_ff |-> last_out_ff && slot_out_ff == SLOT_FIRST &&
      pos_x_ff == 17'd0 && pos_y_ff == 17'd0 && pos_z_ff == 17'd0)
      else $error("A bad cell must give a single zero word.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !bad_out_ff |-> last_out_ff == (slot_out_ff == SLOT_LAST))
      else $error("Last flag out of step with the corner slot.");
   assert property (@(posedge clock) disable iff (reset)
      cur_vld_ff && !cur_ff.bad |-> slot_ff <= SLOT_LAST)
      else $error("Corner sequencer ran past the sixth vertex.");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> adv && (!cur_vld_ff || done))
      else $error("Cell taken while the current one is unfinished.");

endmodule

[hw/rtl/uv_sphere_cell_vertex_generator.sv]
// Turns one grid cell (ring, sector) of a UV sphere into the six vertices of
// its two flat-shaded triangles, in the order a, b, c, a, c, d.
// Cells enter on the req_ channel and vertices leave on the rsp_ channel, both
// valid/ready; each vertex word carries its corner slot and a last flag.
// A cell whose ring or sector index lies at or beyond the effective count
// gives one word with bad_index and last_vertex set and zero coordinates.
// Radius, ring count and sector count are set through the csr_ APB port at
// byte addresses 0, 4 and 8, and must only be changed while the block is idle.
// A two-entry cell queue feeds a pipeline that issues one vertex per cycle
// while cells are queued and the receiver keeps up: angle dividers of
// ANGLE_BITS + 1 steps, sine units of eight stages and three stages of
// scaling and output. A valid cell gives six vertex words and a bad cell one,
// and the next cell is taken from the queue only as the current one issues
// its last word.
// When the receiver holds rsp_ready low the whole pipeline holds; the queue
// still takes up to two further cells.
// Reset empties the queue and the pipeline and returns the registers to a
// radius of 1.0, 16 rings and 32 sectors.
module uv_sphere_cell_vertex_generator #(
   parameter int MAX_RINGS   = ucv_pkg::MAX_RINGS_DEF,
   parameter int MAX_SECTORS = ucv_pkg::MAX_SECTORS_DEF,
   parameter int ANGLE_BITS  = ucv_pkg::ANGLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_ring_index,
   input  logic [7:0]                  req_sector_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [16:0]          rsp_pos_x,
   output logic signed [16:0]          rsp_pos_y,
   output logic signed [16:0]          rsp_pos_z,
   output logic [2:0]                  rsp_corner_slot,
   output logic                        rsp_bad_index,
   output logic                        rsp_last_vertex,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ucv_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import ucv_pkg::*;

   logic [15:0]  radius_ff;
   logic [8:0]   ring_count_ff, sector_count_ff;
   logic [8:0]   rings_eff, sectors_eff;
   logic         wr_en;
   logic         q_valid, q_pop;
   ucv_cell_type q_cell;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff       <= 16'd256;
         ring_count_ff   <= 9'd16;
         sector_count_ff <= 9'd32;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_RADIUS:  radius_ff       <= csr_pwdata[15:0];
            REG_RINGS:   ring_count_ff   <= csr_pwdata[8:0];
            REG_SECTORS: sector_count_ff <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_RADIUS:  csr_prdata = {16'd0, radius_ff};
         REG_RINGS:   csr_prdata = {23'd0, ring_count_ff};
         REG_SECTORS: csr_prdata = {23'd0, sector_count_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign rings_eff   = clamp_count(ring_count_ff, MIN_RINGS, MAX_RINGS);
   assign sectors_eff = clamp_count(sector_count_ff, MIN_SECTORS, MAX_SECTORS);

   ucv_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ring_index   (req_ring_index),
      .req_sector_index (req_sector_index),
      .rings_eff        (rings_eff),
      .sectors_eff      (sectors_eff),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_cell           (q_cell)
   );

   ucv_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_cell          (q_cell),
      .radius          (radius_ff),
      .rings_eff       (rings_eff),
      .sectors_eff     (sectors_eff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_corner_slot (rsp_corner_slot),
      .rsp_bad_index   (rsp_bad_index),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule

[sim/uv_sphere_cell_vertex_generator_tb.sv]
`timescale 1ns / 100ps

module uv_sphere_cell_vertex_generator_tb;
   import ucv_pkg::*;

   localparam int ABITS = ANGLE_BITS_DEF;
   localparam longint unsigned TURN = 64'd1 << ABITS;
   localparam longint unsigned QTURN = 64'd1 << (ABITS - 2);
   localparam longint unsigned ONE30 = 64'd1 << 30;

   typedef struct {
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [16:0] z;
      logic [2:0]         slot;
      logic               bad;
      logic               last;
   } vertex_type;

   // Scoreboard: computes the expected vertex words of each accepted cell and
   // checks the returned words in order.
   class vertex_scoreboard;
      vertex_type pending[$];
      int unsigned mismatches;
      longint unsigned radius_q88;
      longint unsigned rings_cfg;
      longint unsigned sectors_cfg;

      function new();
         mismatches = 0;
         radius_q88 = 256;
         rings_cfg = 16;
         sectors_cfg = 32;
      endfunction

      function longint unsigned quad_sine(longint unsigned xq);
         longint unsigned x2;
         longint unsigned s;
         x2 = (xq * xq) >> 30;
         s = K7 - ((K9 * x2) >> 30);
         s = K5 - ((s * x2) >> 30);
         s = K3 - ((s * x2) >> 30);
         s = K1 - ((s * x2) >> 30);
         s = (s * xq) >> 30;
         return (s > ONE30) ? ONE30 : s;
      endfunction

      function longint unsigned sine16(longint unsigned ang, output bit neg);
         longint unsigned q;
         longint unsigned xq;
         longint unsigned v;
         ang = ang & (TURN - 1);
         q = ang >> (ABITS - 2);
         xq = (ang & (QTURN - 1)) << (32 - ABITS);
         if (q[0]) begin
            xq = ONE30 - xq;
         end
         v = quad_sine(xq);
         neg = (q >= 2) && (v != 0);
         return (v + 8192) >> 14;
      endfunction

      function logic [16:0] signed_field(longint unsigned mag, bit neg);
         longint unsigned v;
         v = neg ? (64'd0 - mag) : mag;
         return v[16:0];
      endfunction

      function void grid_point(longint unsigned i, longint unsigned j,
                               longint unsigned rings, longint unsigned sectors,
                               inout vertex_type v);
         longint unsigned phi, th, sp, cp, st, ct, rsp, mx, mz, my;
         bit nsp, ncp, nst, nct;
         phi = ((i << ABITS) + rings) / (2 * rings);
         th = (((j << ABITS) + sectors / 2) / sectors) & (TURN - 1);
         sp = sine16(phi, nsp);
         cp = sine16(phi + QTURN, ncp);
         st = sine16(th, nst);
         ct = sine16(th + QTURN, nct);
         rsp = radius_q88 * sp;
         mx = (rsp * ct + (64'd1 << 31)) >> 32;
         mz = (rsp * st + (64'd1 << 31)) >> 32;
         my = (radius_q88 * cp + 32768) >> 16;
         v.x = signed_field(mx, (nsp != nct) && mx != 0);
         v.y = signed_field(my, ncp && my != 0);
         v.z = signed_field(mz, (nsp != nst) && mz != 0);
      endfunction

      function void note_cell(logic [7:0] ring, logic [7:0] sector);
         longint unsigned rings, sectors;
         int dr[6] = '{0, 1, 1, 0, 1, 0};
         int ds[6] = '{0, 0, 1, 0, 1, 1};
         vertex_type v;
         rings = (rings_cfg < MIN_RINGS) ? MIN_RINGS :
                 (rings_cfg > MAX_RINGS_DEF) ? MAX_RINGS_DEF : rings_cfg;
         sectors = (sectors_cfg < MIN_SECTORS) ? MIN_SECTORS :
                   (sectors_cfg > MAX_SECTORS_DEF) ? MAX_SECTORS_DEF : sectors_cfg;
         if (ring >= rings || sector >= sectors) begin
            v = '{x: 0, y: 0, z: 0, slot: SLOT_FIRST, bad: 1, last: 1};
            pending.insert(pending.size(), v);
         end else begin
            for (int k = 0; k < 6; k++) begin
               grid_point(ring + dr[k], sector + ds[k], rings, sectors, v);
               v.slot = 3'(k);
               v.bad = 0;
               v.last = (3'(k) == SLOT_LAST);
               pending.insert(pending.size(), v);
            end
         end
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: x=%0d y=%0d z=%0d slot=%0d",
                        got.x, got.y, got.z, got.slot);
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
             got.slot !== want.slot || got.bad !== want.bad ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("word mismatch: exp x=%0d y=%0d z=%0d s=%0d b=%0d l=%0d,",
                        want.x, want.y, want.z, want.slot, want.bad, want.last);
               $display("               got x=%0d y=%0d z=%0d s=%0d b=%0d l=%0d",
                        got.x, got.y, got.z, got.slot, got.bad, got.last);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [7:0] req_ring_index = 0;
   logic [7:0] req_sector_index = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [2:0] rsp_corner_slot;
   logic rsp_bad_index, rsp_last_vertex;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;

   vertex_scoreboard board = new();

   uv_sphere_cell_vertex_generator dut (.*);

   always #5 clock = ~clock;

   // Receiver: ready is chosen at the falling edge, the word sampled at the rising one.
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_vertex('{x: rsp_pos_x, y: rsp_pos_y, z: rsp_pos_z,
                              slot: rsp_corner_slot, bad: rsp_bad_index,
                              last: rsp_last_vertex});
      end
   end

   task automatic send_cell(logic [7:0] ring, logic [7:0] sector);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_ring_index <= ring;
      req_sector_index <= sector;
      do @(posedge clock); while (!req_ready);
      board.note_cell(ring, sector);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_RADIUS:  board.radius_q88 = value[15:0];
         REG_RINGS:   board.rings_cfg = value[8:0];
         REG_SECTORS: board.sectors_cfg = value[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (ABITS + 40) @(negedge clock);
   endtask

   task automatic configure(logic [15:0] rad, logic [8:0] rings, logic [8:0] sectors);
      drain();
      write_reg(REG_RADIUS, {16'd0, rad});
      write_reg(REG_RINGS, {23'd0, rings});
      write_reg(REG_SECTORS, {23'd0, sectors});
   endtask

   // Mostly valid cells for the current counts, some with random indices that may lie out of range.
   task automatic random_cells(int n);
      int rings, sectors;
      rings = (board.rings_cfg < 2) ? 2 : (board.rings_cfg > 256) ? 256 : board.rings_cfg;
      sectors = (board.sectors_cfg < 3) ? 3 :
                (board.sectors_cfg > 256) ? 256 : board.sectors_cfg;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            send_cell(8'($urandom), 8'($urandom));
         else
            send_cell(8'($urandom_range(rings - 1)), 8'($urandom_range(sectors - 1)));
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Reset settings: poles, seam, corners and out-of-range cells.
      send_cell(0, 0);
      send_cell(15, 31);
      send_cell(0, 31);
      send_cell(7, 8);
      send_cell(16, 0);
      send_cell(0, 32);
      send_cell(255, 255);
      send_cell(8, 16);
      configure(16'hFFFF, 9'd0, 9'd0);
      send_cell(0, 0);
      send_cell(1, 2);
      send_cell(2, 0);
      send_cell(0, 3);
      configure(16'd0, 9'd1, 9'd2);
      send_cell(1, 2);
      send_cell(0, 1);
      configure(16'hA5A5, 9'd511, 9'd300);
      send_cell(255, 255);
      send_cell(128, 170);
      send_cell(85, 0);
      configure(16'd256, 9'd256, 9'd256);
      send_cell(255, 0);
      send_cell(0, 255);

      configure(16'($urandom), 9'($urandom_range(2, 40)), 9'($urandom_range(3, 40)));
      random_cells(80);
      send_idle_pct = 85;
      configure(16'($urandom), 9'($urandom), 9'($urandom));
      random_cells(70);
      send_idle_pct = 0;
      recv_stall_pct = 85;
      configure(16'($urandom), 9'($urandom_range(0, 20)), 9'($urandom_range(0, 20)));
      random_cells(70);
      send_idle_pct = 20;
      recv_stall_pct = 20;
      configure(16'hFFFF, 9'd256, 9'd256);
      random_cells(70);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      configure(16'($urandom), 9'($urandom_range(2, 64)), 9'($urandom_range(3, 64)));
      @(negedge clock);
      hold_off = 300;
      random_cells(50);

      drain();
      if (board.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
